### hdl/sga_pkg.sv
// shared types and constants of the scatter-gather address translation unit
`timescale 1ns / 1ps
`default_nettype none

package sga_pkg;

  typedef enum logic {
    CMD_WRITE     = 1'b0,
    CMD_TRANSLATE = 1'b1
  } cmd_e;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_USER_BASE  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_COUNT = 8'd1;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  entry_index;
    logic [31:0] entry_size;
    logic [31:0] entry_physical;
    logic [31:0] user_address;
    logic [31:0] size_wanted;
  } in_t;

  typedef struct packed {
    logic [31:0] physical_address;
    logic [31:0] available_size;
    logic        found;
    logic        insufficient;
  } out_t;

  // decoded command as it travels from the front end to the back end
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  slot;
    logic [31:0] size;
    logic [31:0] phys;
    logic [31:0] offset;
    logic [31:0] wanted;
  } op_t;

endpackage

`default_nettype wire

### hdl/sga_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sga_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/sga_front.sv
// front end: accepts transactions, decodes them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module sga_front
  import sga_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_data_i,
  input  wire logic [31:0] user_base_i,
  output logic             op_valid_o,
  input  wire logic        op_ready_i,
  output op_t              op_o
);

  op_t        fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  logic slot_ok;
  logic push, pop;
  op_t  op_new;

  // writes beyond the list are taken and dropped
  assign slot_ok = 32'(in_data_i.entry_index) < 32'(MAX_PAGES);

  always_comb begin
    op_new.cmd    = in_data_i.command;
    op_new.slot   = in_data_i.entry_index;
    op_new.size   = in_data_i.entry_size;
    op_new.phys   = in_data_i.entry_physical;
    op_new.offset = in_data_i.user_address - user_base_i;
    op_new.wanted = in_data_i.size_wanted;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push = in_valid_i && in_ready_o &&
                !((in_data_i.command == CMD_WRITE) && !slot_ok);
  assign op_valid_o = (count_q != 2'd0);
  assign pop = op_valid_o && op_ready_i;
  assign op_o = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !push)
    else $error("push into full queue");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### hdl/sga_back.sv
// back end: page table writes and the sequential translation walk
`timescale 1ns / 1ps
`default_nettype none

module sga_back
  import sga_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       op_valid_i,
  output logic            op_ready_o,
  input  wire op_t        op_i,
  input  wire logic [8:0] page_count_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o
);

  localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] chk_idx_q, chk_idx_d;
  logic [CW-1:0] limit_q, limit_d;
  logic          pend_q, pend_d;
  logic          hit_q, hit_d;
  logic [31:0]   base_q, base_d;
  logic [31:0]   offset_q, offset_d;
  logic [31:0]   wanted_q, wanted_d;
  logic [31:0]   within_q, within_d;
  logic [31:0]   ent_size_q, ent_size_d;
  logic [31:0]   ent_phys_q, ent_phys_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [CW-1:0] limit_new;
  logic [31:0]   rd_size, rd_phys;
  logic [32:0]   end_sum;
  logic [31:0]   avail;
  logic          out_free;

  // entries are stored as {size, physical}
  sga_ram #(
    .WIDTH(64),
    .DEPTH(MAX_PAGES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // walk length saturates at the table depth
  assign limit_new = (32'(page_count_i) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                           : CW'(page_count_i);

  assign op_ready_o = (state_q == ST_IDLE);
  assign ram_we     = op_valid_i && op_ready_o && (op_i.cmd == CMD_WRITE);
  assign ram_waddr  = AW'(op_i.slot);
  assign ram_wdata  = {op_i.size, op_i.phys};
  assign ram_re     = (state_q == ST_WALK) && (rd_idx_q < limit_q);
  assign ram_raddr  = rd_idx_q[AW-1:0];

  assign rd_size = ram_rdata[63:32];
  assign rd_phys = ram_rdata[31:0];
  // base never exceeds the offset while walking, so 33 bits cover the sum
  assign end_sum = {1'b0, base_q} + {1'b0, rd_size};
  assign avail   = ent_size_q - within_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    chk_idx_d   = chk_idx_q;
    limit_d     = limit_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    base_d      = base_q;
    offset_d    = offset_q;
    wanted_d    = wanted_q;
    within_d    = within_q;
    ent_size_d  = ent_size_q;
    ent_phys_d  = ent_phys_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (op_valid_i && (op_i.cmd == CMD_TRANSLATE)) begin
          offset_d  = op_i.offset;
          wanted_d  = op_i.wanted;
          limit_d   = limit_new;
          base_d    = 32'd0;
          rd_idx_d  = '0;
          chk_idx_d = '0;
          hit_d     = 1'b0;
          state_d   = (limit_new == '0) ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (ram_re) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        pend_d = ram_re;
        if (pend_q) begin
          if (end_sum > {1'b0, offset_q}) begin
            hit_d      = 1'b1;
            within_d   = offset_q - base_q;
            ent_size_d = rd_size;
            ent_phys_d = rd_phys;
            pend_d     = 1'b0;
            state_d    = ST_FIN;
          end else if (chk_idx_q == limit_q - CW'(1)) begin
            pend_d  = 1'b0;
            state_d = ST_FIN;
          end else begin
            base_d    = end_sum[31:0];
            chk_idx_d = chk_idx_q + CW'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (hit_q) begin
            out_d.physical_address = ent_phys_q + within_q;
            out_d.available_size   = avail;
            out_d.found            = 1'b1;
            out_d.insufficient     = avail < wanted_q;
          end else begin
            out_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    limit_q    <= limit_d;
    hit_q      <= hit_d;
    base_q     <= base_d;
    offset_q   <= offset_d;
    wanted_q   <= wanted_d;
    within_q   <= within_d;
    ent_size_q <= ent_size_d;
    ent_phys_q <= ent_phys_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_onehot_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("back end state not one-hot");

  a_pend_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_WALK) && (chk_idx_q < limit_q))
    else $error("read data pending outside the walk");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |->
      (out_q.physical_address == 32'd0) && (out_q.available_size == 32'd0) &&
      !out_q.insufficient)
    else $error("not-found result carries nonzero fields");

  a_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("table write during a walk");

  a_fin_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_free) |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished translation not delivered");

endmodule

`default_nettype wire

### hdl/scatter_gather_address_translate_unit.sv
// top level of the scatter-gather address translation unit
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The input channel carries write and translate transactions. A write stores
// one page entry (size and physical start) at entry_index; slots at or above
// MAX_PAGES are dropped. A translate subtracts user_base from user_address and
// walks the first page_count entries in order to find the entry that holds
// the offset. Writes give no result; every translate gives exactly one.
// Configuration: register 0 is user_base, register 1 is page_count, both
// written over the cfg channel; cfg_ready_o is always high. The user must
// write them only while the block is idle; the block does not enforce this.
// A translate leaves the queue for the back end, whose walk reads the table
// ram, which yields one entry per cycle, up to min(page_count, MAX_PAGES)
// entries until one holds the offset; with page_count zero no walk runs.
// A two-entry queue sits between the decoding front end and the back end,
// so input transactions are taken while a walk runs or a result waits.
// When the receiver stalls, the result stays in the output register and the
// next translate stops before delivery; the queue then fills and in_ready_o
// drops. Reset clears the configuration and control registers; table
// contents are undefined until written, and no clearing pass runs.

module scatter_gather_address_translate_unit
  import sga_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic [31:0] user_base_q;
  logic [8:0]  page_count_q;

  logic op_valid, op_ready;
  op_t  op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_base_q  <= 32'd0;
      page_count_q <= 9'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_USER_BASE: begin
          user_base_q <= cfg_data_i;
        end
        CFG_PAGE_COUNT: begin
          page_count_q <= cfg_data_i[8:0];
        end
        default: begin
        end
      endcase
    end
  end

  sga_front #(
    .MAX_PAGES(MAX_PAGES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .user_base_i(user_base_q),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  sga_back #(
    .MAX_PAGES(MAX_PAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .page_count_i(page_count_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
